// ----- rtl/drdm_pkg.sv -----
// ----------------------------------------------------------------------------
// drdm_pkg
// Shared types and constants for the data run decoder and mapper: run table
// sizing, status codes, parser phases and the stored run entry layout.
// ----------------------------------------------------------------------------
package drdm_pkg;

  // run table sizing
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int CLU_W    = 64;
  localparam int STATUS_W = 3;
  localparam int NIB_W    = 4;

  // largest byte count a header nibble may give
  localparam logic [NIB_W-1:0] MAX_FIELD_BYTES = 4'd8;

  // item kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_TAKEN    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ENDED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FORMAT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MAPPED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_HOLE     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd6;

  // run list parser phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_DELTA  = 2'd2;
  localparam logic [1:0] PH_ENDED  = 2'd3;

  // logical cluster reported when no run covers the query
  localparam logic [CLU_W-1:0] LCN_INVALID = 64'hFFFF_FFFF_FFFF_FFFE;

  // one stored run
  typedef struct packed {
    logic             hole;
    logic [CLU_W-1:0] lcn;
    logic [CLU_W-1:0] vcn;
    logic [CLU_W-1:0] len;
  } run_entry_t;

  localparam int ENTRY_W = $bits(run_entry_t);

endpackage

// ----- rtl/drdm_ram.sv -----
// ----------------------------------------------------------------------------
// drdm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module drdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/data_run_decoder_and_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// data_run_decoder_and_mapper_unit
// Decodes an encoded run list one byte per item into a run table and maps
// virtual clusters to logical clusters by walking that table in order.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_stall  | kind, data_byte, query_vcn
//  output  | out_valid / out_stall| status, table_fill, cluster_lcn,
//          |                      | run_first_vcn, run_length
//
//  A run list byte passes S_BYTE and S_EMIT; a byte that finishes a run with
//  delta bytes adds S_LCN and S_STORE, and one that finishes a hole run adds S_STORE.
//  A lookup passes S_LK_RD, S_LK_SUB and S_LK_CMP for each run examined,
//  S_LK_ADD when the run is mapped, and S_EMIT at the end:
//  each run costs a table read, a subtract and a compare on the one 64-bit
//  adder/subtractor that all 64-bit sums in the block share.
//  One item is in work at a time; in_stall is high during reset and from
//  acceptance until the result is loaded into the output register.
//  A stalled output holds the block until the result register frees up.
//  Reset is synchronous; the run table itself is not cleared, only the
//  run count, so no clearing pass runs.
//
module data_run_decoder_and_mapper_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [7:0]                          data_byte,
  input  logic [drdm_pkg::CLU_W-1:0]          query_vcn,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [drdm_pkg::STATUS_W-1:0]       status,
  output logic [drdm_pkg::CNT_W-1:0]          table_fill,
  output logic [drdm_pkg::CLU_W-1:0]          cluster_lcn,
  output logic [drdm_pkg::CLU_W-1:0]          run_first_vcn,
  output logic [drdm_pkg::CLU_W-1:0]          run_length
);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_BYTE   = 4'd1;
  localparam logic [3:0] S_LCN    = 4'd2;
  localparam logic [3:0] S_STORE  = 4'd3;
  localparam logic [3:0] S_LK_RD  = 4'd4;
  localparam logic [3:0] S_LK_SUB = 4'd5;
  localparam logic [3:0] S_LK_CMP = 4'd6;
  localparam logic [3:0] S_LK_ADD = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  localparam int W = drdm_pkg::CLU_W;

  logic [3:0] state;

  // latched item
  logic [7:0]   item_byte;
  logic [W-1:0] item_vcn;

  // parser state
  logic [1:0]                       phase;
  logic [drdm_pkg::NIB_W-1:0]       len_bytes;
  logic [drdm_pkg::NIB_W-1:0]       off_bytes;
  logic [drdm_pkg::NIB_W-1:0]       byte_index;
  logic [W-1:0]                     length_acc;
  logic [W-1:0]                     delta_acc;
  logic [W-1:0]                     running_lcn;
  logic [W-1:0]                     running_vcn;
  logic [drdm_pkg::CNT_W-1:0]       entries_held;
  logic                             run_hole;

  // lookup walk
  logic [drdm_pkg::CNT_W-1:0] idx;
  logic [W-1:0]               diff;
  logic                       vcn_ge;

  // pending result
  logic [drdm_pkg::STATUS_W-1:0] res_status;
  logic [W-1:0]                  res_lcn;
  logic [W-1:0]                  res_vcn;
  logic [W-1:0]                  res_len;

  // run table
  logic                 tbl_wr_en;
  drdm_pkg::run_entry_t tbl_wr_data;
  drdm_pkg::run_entry_t tbl_rd_data;
  logic [drdm_pkg::ENTRY_W-1:0] tbl_rd_raw;

  // shared adder / subtractor
  logic [W-1:0] add_a;
  logic [W-1:0] add_b;
  logic         add_sub;
  logic [W:0]   add_sum;

  // byte decode helpers
  logic [drdm_pkg::NIB_W-1:0] hdr_ln;
  logic [drdm_pkg::NIB_W-1:0] hdr_on;
  logic [drdm_pkg::NIB_W-1:0] idx_inc;
  logic [W-1:0]               byte_lane;
  logic [W-1:0]               sign_fill;
  logic                       table_full_next;

  assign in_stall = rst || (state != S_IDLE);

  // header nibbles and byte placement
  always_comb begin
    hdr_ln    = item_byte[3:0];
    hdr_on    = item_byte[7:4];
    idx_inc   = byte_index + drdm_pkg::NIB_W'(1);
    byte_lane = W'(item_byte) << {byte_index[2:0], 3'b000};
    sign_fill = '0;
    if (item_byte[7] && (off_bytes < drdm_pkg::MAX_FIELD_BYTES)) begin
      sign_fill = {W{1'b1}} << {off_bytes[2:0], 3'b000};
    end
    table_full_next = ((entries_held + drdm_pkg::CNT_W'(1)) >=
                       drdm_pkg::CNT_W'(drdm_pkg::TABLE_DEPTH));
  end

  // operand select for the shared adder
  always_comb begin
    unique case (state)
      S_LCN: begin
        add_a = running_lcn; add_b = delta_acc; add_sub = 1'b0;
      end
      S_STORE: begin
        add_a = running_vcn; add_b = length_acc; add_sub = 1'b0;
      end
      S_LK_SUB: begin
        add_a = item_vcn; add_b = tbl_rd_data.vcn; add_sub = 1'b1;
      end
      S_LK_CMP: begin
        add_a = diff; add_b = tbl_rd_data.len; add_sub = 1'b1;
      end
      S_LK_ADD: begin
        add_a = tbl_rd_data.lcn; add_b = diff; add_sub = 1'b0;
      end
      default: begin
        add_a = '0; add_b = '0; add_sub = 1'b0;
      end
    endcase
    add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (W+1)'(add_sub);
  end

  // table write of the finished run
  always_comb begin
    tbl_wr_en        = (state == S_STORE) &&
                       (entries_held < drdm_pkg::CNT_W'(drdm_pkg::TABLE_DEPTH));
    tbl_wr_data.hole = run_hole;
    tbl_wr_data.lcn  = run_hole ? '0 : running_lcn;
    tbl_wr_data.vcn  = running_vcn;
    tbl_wr_data.len  = length_acc;
  end

  assign tbl_rd_data = drdm_pkg::run_entry_t'(tbl_rd_raw);

  drdm_ram #(
    .WIDTH (drdm_pkg::ENTRY_W),
    .DEPTH (drdm_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (entries_held[drdm_pkg::IDX_W-1:0]),
    .wr_data (tbl_wr_data),
    .rd_addr (idx[drdm_pkg::IDX_W-1:0]),
    .rd_data (tbl_rd_raw)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= drdm_pkg::PH_HEADER;
      entries_held <= '0;
      len_bytes    <= '0;
      off_bytes    <= '0;
      byte_index   <= '0;
      length_acc   <= '0;
      delta_acc    <= '0;
      running_lcn  <= '0;
      running_vcn  <= '0;
      out_valid    <= 1'b0;
    end else begin
      // output valid: set when a result loads, cleared when the item is taken
      if (state == S_EMIT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_byte <= data_byte;
            item_vcn  <= query_vcn;
            idx       <= '0;
            state     <= (kind == drdm_pkg::KIND_LOOKUP) ? S_LK_RD : S_BYTE;
          end
        end

        S_BYTE: begin
          res_status <= drdm_pkg::ST_TAKEN;
          res_lcn    <= '0;
          res_vcn    <= '0;
          res_len    <= '0;
          state      <= S_EMIT;
          if (phase == drdm_pkg::PH_HEADER || phase == drdm_pkg::PH_ENDED) begin
            // a byte after the end starts a fresh list
            if (phase == drdm_pkg::PH_ENDED) begin
              entries_held <= '0;
              running_lcn  <= '0;
              running_vcn  <= '0;
            end
            len_bytes  <= '0;
            off_bytes  <= '0;
            byte_index <= '0;
            length_acc <= '0;
            delta_acc  <= '0;
            if (item_byte == 8'd0) begin
              phase      <= drdm_pkg::PH_ENDED;
              res_status <= drdm_pkg::ST_ENDED;
            end else if (hdr_ln > drdm_pkg::MAX_FIELD_BYTES ||
                         hdr_on > drdm_pkg::MAX_FIELD_BYTES) begin
              phase      <= drdm_pkg::PH_ENDED;
              res_status <= drdm_pkg::ST_FORMAT;
            end else begin
              len_bytes <= hdr_ln;
              off_bytes <= hdr_on;
              phase     <= (hdr_ln != '0) ? drdm_pkg::PH_LENGTH : drdm_pkg::PH_DELTA;
            end
          end else if (phase == drdm_pkg::PH_LENGTH) begin
            // little-endian run length
            length_acc <= length_acc | byte_lane;
            if (idx_inc >= len_bytes) begin
              byte_index <= '0;
              if (off_bytes == '0) begin
                run_hole <= 1'b1;
                state    <= S_STORE;
              end else begin
                phase <= drdm_pkg::PH_DELTA;
              end
            end else begin
              byte_index <= idx_inc;
            end
          end else begin
            // little-endian delta, sign-extended on its last byte
            byte_index <= idx_inc;
            if (idx_inc >= off_bytes) begin
              delta_acc <= delta_acc | byte_lane | sign_fill;
              run_hole  <= 1'b0;
              state     <= S_LCN;
            end else begin
              delta_acc <= delta_acc | byte_lane;
            end
          end
        end

        S_LCN: begin
          running_lcn <= add_sum[W-1:0];
          state       <= S_STORE;
        end

        S_STORE: begin
          if (tbl_wr_en) begin
            entries_held <= entries_held + drdm_pkg::CNT_W'(1);
          end
          running_vcn <= add_sum[W-1:0];
          phase       <= table_full_next ? drdm_pkg::PH_ENDED : drdm_pkg::PH_HEADER;
          len_bytes   <= '0;
          off_bytes   <= '0;
          byte_index  <= '0;
          length_acc  <= '0;
          delta_acc   <= '0;
          res_status  <= drdm_pkg::ST_STORED;
          res_lcn     <= run_hole ? '0 : running_lcn;
          res_vcn     <= running_vcn;
          res_len     <= length_acc;
          state       <= S_EMIT;
        end

        S_LK_RD: begin
          // read of entry idx is in flight
          if (idx == entries_held) begin
            res_status <= drdm_pkg::ST_NOTFOUND;
            res_lcn    <= drdm_pkg::LCN_INVALID;
            res_vcn    <= '0;
            res_len    <= '0;
            state      <= S_EMIT;
          end else begin
            state <= S_LK_SUB;
          end
        end

        S_LK_SUB: begin
          // offset into the run, carry out means no borrow
          diff   <= add_sum[W-1:0];
          vcn_ge <= add_sum[W];
          state  <= S_LK_CMP;
        end

        S_LK_CMP: begin
          // offset below length shows as a borrow
          if (vcn_ge && !add_sum[W]) begin
            res_vcn <= '0;
            res_len <= '0;
            if (tbl_rd_data.hole) begin
              res_status <= drdm_pkg::ST_HOLE;
              res_lcn    <= '0;
              state      <= S_EMIT;
            end else begin
              state <= S_LK_ADD;
            end
          end else begin
            idx   <= idx + drdm_pkg::CNT_W'(1);
            state <= S_LK_RD;
          end
        end

        S_LK_ADD: begin
          res_status <= drdm_pkg::ST_MAPPED;
          res_lcn    <= add_sum[W-1:0];
          state      <= S_EMIT;
        end

        S_EMIT: begin
          // load the result once the output register is free
          if (!out_valid || !out_stall) begin
            status        <= res_status;
            table_fill    <= entries_held;
            cluster_lcn   <= res_lcn;
            run_first_vcn <= res_vcn;
            run_length    <= res_len;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/drdm_checker.sv -----
// ----------------------------------------------------------------------------
// drdm_checker
// Port level checks on the data run decoder and mapper results, bound to
// the top level.
// ----------------------------------------------------------------------------
module drdm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [drdm_pkg::STATUS_W-1:0] status,
  input logic [drdm_pkg::CNT_W-1:0]    table_fill,
  input logic [drdm_pkg::CLU_W-1:0]    cluster_lcn,
  input logic [drdm_pkg::CLU_W-1:0]    run_first_vcn,
  input logic [drdm_pkg::CLU_W-1:0]    run_length
);

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= drdm_pkg::ST_NOTFOUND))
    else $error("status code out of range");

  // run fields only carry data on a stored run
  a_run_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != drdm_pkg::ST_STORED) |->
      (run_first_vcn == '0 && run_length == '0))
    else $error("run fields set on a result that stores no run");

  // a miss reports the invalid cluster
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == drdm_pkg::ST_NOTFOUND) |->
      (cluster_lcn == drdm_pkg::LCN_INVALID))
    else $error("not found result without invalid cluster");

  // results that map nothing carry a zero cluster
  a_zero_lcn: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == drdm_pkg::ST_TAKEN || status == drdm_pkg::ST_ENDED ||
                   status == drdm_pkg::ST_FORMAT || status == drdm_pkg::ST_HOLE)) |->
      (cluster_lcn == '0))
    else $error("nonzero cluster on a result that maps nothing");

  // table never reports more runs than it holds
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (table_fill <= drdm_pkg::CNT_W'(drdm_pkg::TABLE_DEPTH)))
    else $error("run count above table size");

endmodule

bind data_run_decoder_and_mapper_unit drdm_checker u_drdm_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .table_fill    (table_fill),
  .cluster_lcn   (cluster_lcn),
  .run_first_vcn (run_first_vcn),
  .run_length    (run_length)
);
